[sv/spc_pkg.sv]
// shared types and constants for the stack permutation checker
package spc_pkg;

  // width of the value fields on the input ports
  localparam int FIELD_W = 16;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;   // take the input word: queue target, push value
    logic pop;      // pop stack top and retire oldest target
    logic finish;   // load the verdict and clear the sequence state
  } spc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic match;     // stack top equals oldest pending target
    logic last_seen; // accepted word ended the sequence
    logic out_busy;  // result register holds a word not taken this cycle
  } spc_status_t;

endpackage

[sv/spc_ctrl.sv]
// controller state machine for the stack permutation checker
module spc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spc_pkg::spc_status_t status,
  output spc_pkg::spc_cmd_t    cmd
);
  import spc_pkg::*;

  typedef enum logic [0:0] {
    S_IDLE,
    S_CMP
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (status.match) begin
          cmd.pop = 1'b1;
        end else if (status.last_seen) begin
          if (!status.out_busy) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered ready, ready held low while in reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

[sv/spc_dp.sv]
// datapath for the stack permutation checker: stack, target queue, counters, result
module spc_dp #(
  parameter int MAX_LEN    = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  spc_pkg::spc_cmd_t           cmd,
  output spc_pkg::spc_status_t        status,
  input  logic [spc_pkg::FIELD_W-1:0] push_value,
  input  logic [spc_pkg::FIELD_W-1:0] pop_value,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        is_valid,
  output logic                        overflow
);
  import spc_pkg::*;

  localparam int KEEP_W = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W  = $clog2(MAX_LEN + 1);

  logic [KEEP_W-1:0] stack_mem [MAX_LEN];
  logic [KEEP_W-1:0] queue_mem [MAX_LEN];

  logic [CNT_W-1:0]  stack_count;
  logic [CNT_W-1:0]  read_index;
  logic [CNT_W-1:0]  write_index;
  logic              overflow_seen;
  logic              last_seen;
  logic [KEEP_W-1:0] top_value;
  logic [KEEP_W-1:0] head_value;

  logic [KEEP_W-1:0] push_keep;
  logic [KEEP_W-1:0] pop_keep;
  logic              full;
  logic [CNT_W-1:0]  stack_below;
  logic [CNT_W-1:0]  read_after;

  assign push_keep   = push_value[KEEP_W-1:0];
  assign pop_keep    = pop_value[KEEP_W-1:0];
  assign full        = (write_index == CNT_W'(MAX_LEN));
  assign stack_below = stack_count - CNT_W'(2);
  assign read_after  = read_index + CNT_W'(1);

  // status towards the controller
  assign status.match     = (stack_count != '0) && (read_index < write_index) &&
                            (top_value == head_value);
  assign status.last_seen = last_seen;
  assign status.out_busy  = out_valid && !out_ready;

  // stack memory with registered top read
  always_ff @(posedge clk) begin
    if (cmd.accept && !full) begin
      stack_mem[stack_count[ADDR_W-1:0]] <= push_keep;
      top_value                          <= push_keep;
    end else if (cmd.pop) begin
      top_value <= stack_mem[stack_below[ADDR_W-1:0]];
    end
  end

  // target queue memory with registered head read
  always_ff @(posedge clk) begin
    if (cmd.accept && !full) begin
      queue_mem[write_index[ADDR_W-1:0]] <= pop_keep;
      if (read_index == write_index) begin
        head_value <= pop_keep;
      end
    end else if (cmd.pop) begin
      head_value <= queue_mem[read_after[ADDR_W-1:0]];
    end
  end

  // last flag of the accepted word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_seen <= last;
    end
  end

  // counters and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count   <= '0;
      read_index    <= '0;
      write_index   <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.finish) begin
      stack_count   <= '0;
      read_index    <= '0;
      write_index   <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.accept) begin
      if (full) begin
        overflow_seen <= 1'b1;
      end else begin
        stack_count <= stack_count + CNT_W'(1);
        write_index <= write_index + CNT_W'(1);
      end
    end else if (cmd.pop) begin
      stack_count <= stack_count - CNT_W'(1);
      read_index  <= read_after;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      is_valid <= (stack_count == '0) && !overflow_seen;
      overflow <= overflow_seen;
    end
  end

  // every accepted value is either on the stack or already popped
  a_count_balance: assert property (@(posedge clk) disable iff (rst)
    (CNT_W'(stack_count + read_index) == write_index))
    else $error("stack count does not match pushes minus pops");

  // never more targets retired than queued
  a_read_behind_write: assert property (@(posedge clk) disable iff (rst)
    (read_index <= write_index))
    else $error("target read index passed write index");

  // a pop only happens on a non-empty stack with a pending target
  a_pop_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (stack_count != '0) && (read_index < write_index))
    else $error("pop without stack entry or pending target");

  // finishing presents a word and clears the sequence
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid && (write_index == '0) && !overflow_seen)
    else $error("finish did not present result or clear state");

endmodule

[sv/stack_permutation_checker.sv]
// stack permutation checker: does a pop order follow from a push order through one stack
// an accepted word enters the compare state, popping while stack top and oldest target match;
//   on the last word the result word is registered after that run, once the result register is free
// in_ready stays low during the compare run, so no new word is taken until it ends;
//   the stack top and queue head are read into registers again on each pop
// reset: synchronous, clears state, counters, overflow flag and result valid; memories are not cleared
module stack_permutation_checker #(
  parameter int MAX_LEN    = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [spc_pkg::FIELD_W-1:0] push_value,
  input  logic [spc_pkg::FIELD_W-1:0] pop_value,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        is_valid,
  output logic                        overflow
);
  import spc_pkg::*;

  spc_cmd_t    cmd;
  spc_status_t status;

  // control sequencing
  spc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // stack, queue and result storage
  spc_dp #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .push_value (push_value),
    .pop_value  (pop_value),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_valid   (is_valid),
    .overflow   (overflow)
  );

endmodule
